### design/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers shared by the RTL modules.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// implication, antecedent and consequent given as one property expression
`define ASSERT_IMPLY(label, clk, rst_n, seq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) seq) \
        else $error("%m: implication failed");

`endif

### design/udec_pkg.sv
// udec_pkg: request types, work records, characters and hex helpers for the
// URL percent decoder. Depends on nothing.
package udec_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_terminator;
        logic [15:0] decoded_length;
        logic        last_of_run;
    } t_out_req;

    // up to three decoded bytes plus an optional terminator for one input request
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] ndata;
        logic       term;
    } t_work;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    // letters: low nibble 1..6 maps to 10..15
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= CH_9) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + (HEX_TEN - 4'd1);
        end
        return v;
    endfunction

endpackage

### design/udec_front.sv
// udec_front: escape tracking and classification of accepted requests into
// work records. Depends on udec_pkg.
module udec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  udec_pkg::t_in_req i_req,
    output logic              o_push,
    output udec_pkg::t_work   o_work
);

    `include "assert_macros.svh"

    udec_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_held, n_held;
    udec_pkg::t_work  w;
    logic [7:0]       c;
    logic [7:0]       pb;
    logic             c_hex;
    logic             c_pct;

    assign c     = i_req.char_byte;
    assign c_hex = udec_pkg::is_hex(c);
    assign c_pct = (c == udec_pkg::CH_PCT);
    assign pb    = (c == udec_pkg::CH_PLUS) ? udec_pkg::CH_SPACE : c;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        w       = '0;
        if (i_req.kind == udec_pkg::KIND_END) begin
            w.term  = 1'b1;
            n_phase = udec_pkg::PH_IDLE;
            n_held  = '0;
            case (r_phase)
                udec_pkg::PH_PCT: begin
                    w.b0    = udec_pkg::CH_QMARK;
                    w.ndata = 2'd1;
                end
                udec_pkg::PH_DIG: begin
                    w.b0    = udec_pkg::CH_QMARK;
                    w.b1    = r_held;
                    w.ndata = 2'd2;
                end
                default: w.ndata = 2'd0;
            endcase
        end else begin
            case (r_phase)
                udec_pkg::PH_PCT: begin
                    if (c_hex) begin
                        n_held  = c;
                        n_phase = udec_pkg::PH_DIG;
                    end else begin
                        w.b0 = udec_pkg::CH_QMARK;
                        if (c_pct) begin
                            w.ndata = 2'd1;
                            n_phase = udec_pkg::PH_PCT;
                        end else begin
                            w.b1    = pb;
                            w.ndata = 2'd2;
                            n_phase = udec_pkg::PH_IDLE;
                        end
                    end
                end
                udec_pkg::PH_DIG: begin
                    n_held = '0;
                    if (c_hex) begin
                        w.b0    = {udec_pkg::hex_val(r_held), udec_pkg::hex_val(c)};
                        w.ndata = 2'd1;
                        n_phase = udec_pkg::PH_IDLE;
                    end else begin
                        w.b0 = udec_pkg::CH_QMARK;
                        w.b1 = r_held;
                        if (c_pct) begin
                            w.ndata = 2'd2;
                            n_phase = udec_pkg::PH_PCT;
                        end else begin
                            w.b2    = pb;
                            w.ndata = 2'd3;
                            n_phase = udec_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    if (c_pct) begin
                        n_phase = udec_pkg::PH_PCT;
                    end else begin
                        w.b0    = pb;
                        w.ndata = 2'd1;
                        n_phase = udec_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_work = w;
    assign o_push = i_take && ((w.ndata != 2'd0) || w.term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= udec_pkg::PH_IDLE;
            r_held  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    `ASSERT_IMPLY(a_end_clears_phase, i_clk, i_rst_n,
        (i_take && i_req.kind == udec_pkg::KIND_END) |=> (r_phase == udec_pkg::PH_IDLE))
    `ASSERT_IMPLY(a_dig_holds_hex, i_clk, i_rst_n,
        (r_phase == udec_pkg::PH_DIG) |-> udec_pkg::is_hex(r_held))

endmodule

### design/udec_fifo.sv
// udec_fifo: short queue of work records between front and back.
// Depends on udec_pkg.
module udec_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  udec_pkg::t_work i_data,
    input  logic            i_pop,
    output udec_pkg::t_work o_data,
    output logic            o_full,
    output logic            o_empty
);

    `include "assert_macros.svh"

    udec_pkg::t_work           r_mem [udec_pkg::Q_DEPTH];
    logic [udec_pkg::Q_AW-1:0] r_wp;
    logic [udec_pkg::Q_AW-1:0] r_rp;
    logic [udec_pkg::Q_AW:0]   r_cnt;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_cnt == (udec_pkg::Q_AW+1)'(udec_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n,
        r_cnt <= (udec_pkg::Q_AW+1)'(udec_pkg::Q_DEPTH))

endmodule

### design/udec_back.sv
// udec_back: expands work records into result requests, one per cycle
// unless stalled; keeps the saturating decoded length. Needs udec_pkg.
module udec_back #(
    parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  udec_pkg::t_work    i_work,
    input  logic               i_avail,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output udec_pkg::t_out_req o_req
);

    `include "assert_macros.svh"

    udec_pkg::t_out_req r_out, n_out;
    logic               r_valid;
    logic [1:0]         r_idx;
    logic [15:0]        r_len, n_len;
    logic [2:0]         total;
    logic               is_last;
    logic               is_data;
    logic               load;
    logic               step;
    logic [7:0]         sel_byte;

    assign total   = {1'b0, i_work.ndata} + {2'b00, i_work.term};
    assign is_last = ({1'b0, r_idx} == (total - 3'd1));
    assign is_data = (r_idx < i_work.ndata);
    assign load    = !r_valid || i_pop;
    assign step    = load && i_avail;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_work.b0;
            2'd1:    sel_byte = i_work.b1;
            2'd2:    sel_byte = i_work.b2;
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        n_out             = '0;
        n_out.last_of_run = is_last;
        if (is_data) begin
            n_out.out_byte = sel_byte;
            n_len          = (r_len < LEN_CAP) ? r_len + 16'd1 : r_len;
        end else begin
            n_out.is_terminator  = 1'b1;
            n_out.decoded_length = r_len;
            n_len                = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_len   <= '0;
        end else if (step) begin
            r_valid <= 1'b1;
            r_len   <= n_len;
            r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (load) begin
            r_valid <= 1'b0;
        end
    end

    assign o_take  = step && is_last;
    assign o_empty = !r_valid;
    assign o_req   = r_out;

    `ASSERT_ALWAYS(a_len_cap, i_clk, i_rst_n, r_len <= LEN_CAP)
    `ASSERT_IMPLY(a_idx_in_record, i_clk, i_rst_n,
        i_avail |-> ({1'b0, r_idx} < total))

endmodule

### design/url_percent_decoder_unit.sv
// url_percent_decoder_unit: top level of the streaming URL percent decoder.
// Depends on udec_pkg, udec_front, udec_fifo, udec_back.
//
//   channel   handshake         payload
//   input     push / full       i_in_req  (kind, char_byte)
//   result    pop / empty       o_out_req (out_byte, is_terminator,
//                                          decoded_length, last_of_run)
//
// The front classifies one request per cycle while the queue is not full; the
// back delivers one result per cycle while results are popped, so an input
// giving k results holds the back for all k. A four-entry record queue sits
// between them and sets how far the input runs ahead; results are registered.
// Reset is synchronous, active low; no clearing pass is needed.
module url_percent_decoder_unit #(
    parameter longint unsigned MAX_LENGTH = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  udec_pkg::t_in_req  i_in_req,
    output logic               empty,
    input  logic               pop,
    output udec_pkg::t_out_req o_out_req
);

    localparam logic [15:0] LEN_CAP =
        (MAX_LENGTH < 64'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

    logic            take;
    logic            f_push;
    udec_pkg::t_work f_work;
    udec_pkg::t_work q_work;
    logic            q_empty;
    logic            q_pop;

    assign take = push && !full;

    udec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_in_req),
        .o_push  (f_push),
        .o_work  (f_work)
    );

    udec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_work),
        .i_pop   (q_pop),
        .o_data  (q_work),
        .o_full  (full),
        .o_empty (q_empty)
    );

    udec_back #(
        .LEN_CAP (LEN_CAP)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (q_work),
        .i_avail (!q_empty),
        .o_take  (q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_req   (o_out_req)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for url_percent_decoder_unit, with a directed table then random strings.
// Depends on udec_pkg and the decoder RTL; predicts results and compares them per field.
module tb;

    localparam longint unsigned TB_MAX_LEN = 255;
    localparam logic [15:0] LEN_CAP = 16'((TB_MAX_LEN < 65535) ? TB_MAX_LEN : 65535);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 140;

    typedef struct {
        udec_pkg::t_in_req  req;
        bit                 pinned;
        udec_pkg::t_out_req want;
    } t_dir_row;

    localparam udec_pkg::t_out_req NO_PIN = '0;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    udec_pkg::t_in_req  i_in_req;
    logic               empty;
    logic               pop;
    udec_pkg::t_out_req o_out_req;

    udec_pkg::t_phase   esc_phase;
    logic [7:0]         esc_digit;
    logic [15:0]        dec_count;
    udec_pkg::t_out_req request_output[$];
    udec_pkg::t_out_req pending_decoded[$];
    udec_pkg::t_out_req want;
    int                 errors;
    int                 cycle_count;
    bit                 calm;

    t_dir_row dir_rows [25] = '{
        '{'{udec_pkg::KIND_END,  8'hA5}, 1'b1, '{8'h00, 1'b1, 16'd0, 1'b1}},
        '{'{udec_pkg::KIND_CHAR, 8'h61}, 1'b1, '{8'h61, 1'b0, 16'd0, 1'b1}},
        '{'{udec_pkg::KIND_CHAR, 8'h2B}, 1'b1, '{8'h20, 1'b0, 16'd0, 1'b1}},
        '{'{udec_pkg::KIND_CHAR, 8'h00}, 1'b1, '{8'h00, 1'b0, 16'd0, 1'b1}},
        '{'{udec_pkg::KIND_CHAR, 8'hFF}, 1'b1, '{8'hFF, 1'b0, 16'd0, 1'b1}},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h34}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h31}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h66}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h46}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h47}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h32}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h30}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h61}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h7A}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_END,  8'h00}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h25}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_CHAR, 8'h42}, 1'b0, NO_PIN},
        '{'{udec_pkg::KIND_END,  8'hFF}, 1'b0, NO_PIN}
    };

    url_percent_decoder_unit #(
        .MAX_LENGTH(TB_MAX_LEN)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_in_req (i_in_req),
        .empty    (empty),
        .pop      (pop),
        .o_out_req(o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    assign calm = (cycle_count >= 80) && (cycle_count < 160);

    function automatic int hex_digit(input logic [7:0] c);
        if (c inside {[udec_pkg::CH_0:udec_pkg::CH_9]}) return int'(c - udec_pkg::CH_0);
        if (c inside {[udec_pkg::CH_UA:udec_pkg::CH_UF]}) return int'(c - udec_pkg::CH_UA) + 10;
        if (c inside {[udec_pkg::CH_LA:udec_pkg::CH_LF]}) return int'(c - udec_pkg::CH_LA) + 10;
        return -1;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        request_output.push_back(udec_pkg::t_out_req'{out_byte: b, is_terminator: 1'b0,
                                 decoded_length: 16'd0, last_of_run: 1'b0});
        if (dec_count < LEN_CAP) dec_count++;
    endtask

    task automatic plain_byte(input logic [7:0] c);
        if (c == udec_pkg::CH_PCT) begin
            esc_phase = udec_pkg::PH_PCT;
        end else if (c == udec_pkg::CH_PLUS) begin
            emit_byte(udec_pkg::CH_SPACE);
        end else begin
            emit_byte(c);
        end
    endtask

    // fills request_output with the results one request causes
    task automatic decode_request(input udec_pkg::t_in_req r);
        int hi;
        int lo;
        request_output.delete();
        if (r.kind == udec_pkg::KIND_END) begin
            if (esc_phase == udec_pkg::PH_PCT) begin
                emit_byte(udec_pkg::CH_QMARK);
            end else if (esc_phase == udec_pkg::PH_DIG) begin
                emit_byte(udec_pkg::CH_QMARK);
                emit_byte(esc_digit);
            end
            request_output.push_back(udec_pkg::t_out_req'{out_byte: 8'h00,
                                     is_terminator: 1'b1, decoded_length: dec_count,
                                     last_of_run: 1'b0});
            esc_phase = udec_pkg::PH_IDLE;
            esc_digit = 8'h00;
            dec_count = 16'd0;
        end else if (esc_phase == udec_pkg::PH_PCT) begin
            if (hex_digit(r.char_byte) >= 0) begin
                esc_digit = r.char_byte;
                esc_phase = udec_pkg::PH_DIG;
            end else begin
                esc_phase = udec_pkg::PH_IDLE;
                emit_byte(udec_pkg::CH_QMARK);
                plain_byte(r.char_byte);
            end
        end else if (esc_phase == udec_pkg::PH_DIG) begin
            lo = hex_digit(r.char_byte);
            hi = hex_digit(esc_digit);
            esc_phase = udec_pkg::PH_IDLE;
            if (lo >= 0 && hi >= 0) begin
                emit_byte(8'((hi << 4) | lo));
            end else begin
                emit_byte(udec_pkg::CH_QMARK);
                emit_byte(esc_digit);
                plain_byte(r.char_byte);
            end
            esc_digit = 8'h00;
        end else begin
            esc_phase = udec_pkg::PH_IDLE;
            plain_byte(r.char_byte);
        end
        if (request_output.size() > 0) begin
            request_output[request_output.size() - 1].last_of_run = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("mismatch %s: got %0h, expected %0h, cycle %0d", what, got, exp,
                 cycle_count);
        errors++;
    endtask

    // drives one request, waits for it to be taken, then queues its results
    task automatic send_request(input udec_pkg::t_in_req r, input bit pinned,
                                input udec_pkg::t_out_req pin);
        if (!calm && $urandom_range(99) < 20) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_in_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_request(r);
        if (pinned) begin
            pending_decoded.push_back(pin);
        end else begin
            foreach (request_output[k]) pending_decoded.push_back(request_output[k]);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        send_request(udec_pkg::t_in_req'{kind: udec_pkg::KIND_CHAR, char_byte: c},
                     1'b0, NO_PIN);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(21);
        if (v < 10) return udec_pkg::CH_0 + 8'(v);
        if (v < 16) return udec_pkg::CH_UA + 8'(v - 10);
        return udec_pkg::CH_LA + 8'(v - 16);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (hex_digit(c) >= 0);
        return c;
    endfunction

    always @(posedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_decoded.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_out_req), 32'd0);
            end else begin
                want = pending_decoded.pop_front();
                if (o_out_req.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(o_out_req.out_byte),
                                    32'(want.out_byte));
                if (o_out_req.is_terminator !== want.is_terminator)
                    report_mismatch("is_terminator", 32'(o_out_req.is_terminator),
                                    32'(want.is_terminator));
                if (o_out_req.decoded_length !== want.decoded_length)
                    report_mismatch("decoded_length", 32'(o_out_req.decoded_length),
                                    32'(want.decoded_length));
                if (o_out_req.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 32'(o_out_req.last_of_run),
                                    32'(want.last_of_run));
            end
        end
    end

    initial begin
        int sent;
        int ntok;
        int pick;
        errors    = 0;
        esc_phase = udec_pkg::PH_IDLE;
        esc_digit = 8'h00;
        dec_count = 16'd0;
        i_rst_n   = 1'b0;
        push      = 1'b0;
        i_in_req  = '0;
        pop       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            ntok = $urandom_range(0, 10);
            repeat (ntok) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    send_char(udec_pkg::CH_PCT);
                    send_char(rand_hex());
                    send_char(rand_hex());
                    sent += 3;
                end else if (pick < 60) begin
                    send_char(udec_pkg::CH_PLUS);
                    sent++;
                end else if (pick < 85) begin
                    send_char(8'($urandom_range(255)));
                    sent++;
                end else if (pick < 92) begin
                    send_char(udec_pkg::CH_PCT);
                    send_char(rand_non_hex());
                    sent += 2;
                end else if (pick < 97) begin
                    send_char(udec_pkg::CH_PCT);
                    send_char(rand_hex());
                    send_char(rand_non_hex());
                    sent += 3;
                end else begin
                    send_char(udec_pkg::CH_PCT);
                    if (pick == 99) send_char(rand_hex());
                    sent += 1 + (pick == 99);
                end
            end
            if ($urandom_range(9) != 0) begin
                send_request(udec_pkg::t_in_req'{kind: udec_pkg::KIND_END,
                             char_byte: 8'($urandom_range(255))}, 1'b0, NO_PIN);
                sent++;
            end
        end
        send_request(udec_pkg::t_in_req'{kind: udec_pkg::KIND_END, char_byte: 8'h00},
                     1'b0, NO_PIN);
        push <= 1'b0;

        while (pending_decoded.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_decoded.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
